@@ design/mvna_pkg.sv @@
// Shared types and constants of the mesh vertex normal accumulator.
`default_nettype none

package mvna_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 24;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRI  = 2'd1;
   localparam logic [1:0] OP_EMIT = 2'd2;

   localparam logic [6:0] VIU_RESET = 7'd8;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [5:0]         vertex_slot;
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
      logic signed [23:0] coord_z;
      logic [5:0]         corner_a;
      logic [5:0]         corner_b;
      logic [5:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic [5:0]         normal_index;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate_seen;
      logic               last_normal;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/mesh_vertex_normal_accumulator_unit.sv @@
// Top level: smoothed vertex normal accumulator with memory-held state.
`default_nettype none

// Usage
//  Command channel: an item is taken at a clock edge with start high and busy
//  low. A load (vertex write) never raises busy. A triangle or emit item holds
//  busy until its work is done.
//  Result channel: each beat sits on rsp_data for one cycle with rsp_valid
//  high; the receiver cannot stall, so no result is ever held back.
//  CSR port: APB style, one register (vertices_in_use), paddr not decoded,
//  pready tied high; write only while busy is low.
// Datapath: one shared multiplier serves the cross product and the
//  squares, followed by a bit-serial square root and a shift-subtract
//  divider for each normal component. An emit sends one beat per vertex
//  and skips the normalize, square, root and divide steps for a zero accumulator.
// Reset: synchronous; vertex and accumulator entries read as zero through
//  per-entry valid bits, so no clearing pass is needed. An emit drops all
//  accumulator valid bits at once.
module mesh_vertex_normal_accumulator_unit #(
   parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = mvna_pkg::COORD_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  mvna_pkg::req_type     req_data,
   output logic                  rsp_valid,
   output mvna_pkg::rsp_type     rsp_data,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [1:0]            csr_paddr,
   input  wire  [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import mvna_pkg::*;

   localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW    = COORD_BITS;
   localparam int DW    = CW + 1;          // edge vector component
   localparam int XW    = 2 * CW + 3;      // cross product component
   localparam int MW    = (DW > 31) ? DW : 31;
   localparam int PW    = 2 * MW;
   localparam int SW    = 62;              // sum of squares
   localparam int RW    = 63;              // square root working width
   localparam int NW    = 45;              // dividend width
   localparam int QW    = 15;              // quotient width
   localparam int AW    = 24;              // accumulator width
   localparam logic [6:0] MAXV = 7'(MAX_VERTICES);
   localparam logic signed [24:0] ACC_HI = 25'sd8388607;
   localparam logic signed [24:0] ACC_LO = -25'sd8388608;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RDA   = 5'd1;
   localparam logic [4:0] S_RDB   = 5'd2;
   localparam logic [4:0] S_RDC   = 5'd3;
   localparam logic [4:0] S_RDW   = 5'd4;
   localparam logic [4:0] S_DIFF  = 5'd5;
   localparam logic [4:0] S_CROSS = 5'd6;
   localparam logic [4:0] S_SGN   = 5'd7;
   localparam logic [4:0] S_ZCHK  = 5'd8;
   localparam logic [4:0] S_NORM  = 5'd9;
   localparam logic [4:0] S_SQ    = 5'd10;
   localparam logic [4:0] S_SQRT  = 5'd11;
   localparam logic [4:0] S_DINIT = 5'd12;
   localparam logic [4:0] S_DIV   = 5'd13;
   localparam logic [4:0] S_URD   = 5'd14;
   localparam logic [4:0] S_UWR   = 5'd15;
   localparam logic [4:0] S_ERD   = 5'd16;
   localparam logic [4:0] S_ELD   = 5'd17;
   localparam logic [4:0] S_EOUT  = 5'd18;

   function automatic logic signed [AW-1:0] sat_sub(input logic signed [AW-1:0] acc,
                                                    input logic signed [15:0] d);
      logic signed [AW:0] r;
      r = (AW+1)'(acc) - (AW+1)'(d);
      if (r > ACC_HI) return ACC_HI[AW-1:0];
      if (r < ACC_LO) return ACC_LO[AW-1:0];
      return r[AW-1:0];
   endfunction

   // memories
   logic [3*CW-1:0] vtx_mem [MAX_VERTICES];
   logic [3*AW-1:0] acc_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] vtx_vld_ff, vtx_vld_in;
   logic [MAX_VERTICES-1:0] acc_vld_ff, acc_vld_in;
   logic [3*CW-1:0] vtx_rd_ff;
   logic            vtx_rd_vld_ff;
   logic [3*AW-1:0] acc_rd_ff;
   logic            acc_rd_vld_ff;
   logic [IDX_W-1:0] vtx_raddr, vtx_waddr, acc_raddr, acc_waddr;
   logic             vtx_we, acc_we;
   logic [3*CW-1:0]  vtx_wdata;
   logic [3*AW-1:0]  acc_wdata;

   // control
   logic [4:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [IDX_W-1:0] corner_ff [3];
   logic [IDX_W-1:0] corner_in [3];
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [1:0]       comp_ff, comp_in;
   logic [1:0]       ucnt_ff, ucnt_in;
   logic             flag_ff, flag_in;
   logic [6:0]       viu_ff, viu_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // datapath
   logic signed [CW-1:0] v0_ff [3], v1_ff [3], v2_ff [3];
   logic signed [CW-1:0] v0_in [3], v1_in [3], v2_in [3];
   logic signed [DW-1:0] e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [XW-1:0] cr_ff [3], cr_in [3];
   logic [XW-1:0]        mag_ff [3], mag_in [3];
   logic                 neg_ff [3], neg_in [3];
   logic signed [15:0]   n_ff [3], n_in [3];
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [RW-1:0]        srem_ff, srem_in, root_ff, root_in, sbit_ff, sbit_in;
   logic [30:0]          len_ff, len_in;
   logic [NW-1:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QW-1:0]        q_ff, q_in;

   // scratch
   logic [6:0]         emit_cnt;
   logic               item_go;
   logic [CW-1:0]      vtx_f [3];
   logic [AW-1:0]      acc_f [3];
   logic [XW-1:0]      mag_or;
   logic signed [XW-1:0] xv;
   logic [SW-1:0]      sum_nx;
   logic [RW-1:0]      sq_t;
   logic [NW:0]        trial;
   logic               qbit;
   logic [QW-1:0]      q_nx;
   logic               last_v;
   logic               corners_ok;
   logic [IDX_W-1:0]   cur_corner;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {25'd0, viu_ff};
   assign item_go    = start && (state_ff == S_IDLE);
   assign emit_cnt   = (viu_ff > MAXV) ? MAXV : viu_ff;
   assign last_v     = ((7'(idx_ff) + 7'd1) == emit_cnt);
   assign cur_corner = corner_ff[ucnt_ff];

   always_comb begin
      corners_ok = ({1'b0, req_data.corner_a} < MAXV) && ({1'b0, req_data.corner_b} < MAXV)
                   && ({1'b0, req_data.corner_c} < MAXV);
      for (int i = 0; i < 3; i++) begin
         vtx_f[i] = vtx_rd_vld_ff ? vtx_rd_ff[(2-i)*CW +: CW] : '0;
         acc_f[i] = acc_rd_vld_ff ? acc_rd_ff[(2-i)*AW +: AW] : '0;
      end
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
   end

   // shared multiplier: cross-product terms, then squares
   always_comb begin
      if (state_ff == S_SQ) begin
         mul_a = MW'($signed({1'b0, mag_ff[comp_ff][29:0]}));
         mul_b = mul_a;
      end else begin
         unique case (cnt_ff[3:1])
            3'd0: begin mul_a = MW'(e1_ff[1]); mul_b = MW'(e2_ff[2]); end
            3'd1: begin mul_a = MW'(e1_ff[2]); mul_b = MW'(e2_ff[1]); end
            3'd2: begin mul_a = MW'(e1_ff[2]); mul_b = MW'(e2_ff[0]); end
            3'd3: begin mul_a = MW'(e1_ff[0]); mul_b = MW'(e2_ff[2]); end
            3'd4: begin mul_a = MW'(e1_ff[0]); mul_b = MW'(e2_ff[1]); end
            default: begin mul_a = MW'(e1_ff[1]); mul_b = MW'(e2_ff[0]); end
         endcase
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      ucnt_in      = ucnt_ff;
      flag_in      = flag_ff;
      viu_in       = viu_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      vtx_vld_in   = vtx_vld_ff;
      acc_vld_in   = acc_vld_ff;
      sum_in       = sum_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      sbit_in      = sbit_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      q_in         = q_ff;
      for (int i = 0; i < 3; i++) begin
         corner_in[i] = corner_ff[i];
         v0_in[i]  = v0_ff[i];
         v1_in[i]  = v1_ff[i];
         v2_in[i]  = v2_ff[i];
         e1_in[i]  = e1_ff[i];
         e2_in[i]  = e2_ff[i];
         cr_in[i]  = cr_ff[i];
         mag_in[i] = mag_ff[i];
         neg_in[i] = neg_ff[i];
         n_in[i]   = n_ff[i];
      end
      vtx_we    = 1'b0;
      vtx_waddr = req_data.vertex_slot[IDX_W-1:0];
      vtx_wdata = {CW'(32'(req_data.coord_x)), CW'(32'(req_data.coord_y)),
                   CW'(32'(req_data.coord_z))};
      vtx_raddr = corner_ff[0];
      acc_we    = 1'b0;
      acc_waddr = cur_corner;
      acc_wdata = '0;
      acc_raddr = idx_ff;
      xv        = '0;
      sum_nx    = sum_ff + SW'($unsigned(prod_ff));
      sq_t      = root_ff + sbit_ff;
      trial     = {1'b0, rem_ff} - {1'b0, dvs_ff};
      qbit      = !trial[NW];
      q_nx      = {q_ff[QW-2:0], qbit};

      if (csr_psel && csr_penable && csr_pwrite) begin
         viu_in = csr_pwdata[6:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (item_go) begin
               unique case (req_data.opcode)
                  OP_LOAD: begin
                     if ({1'b0, req_data.vertex_slot} < MAXV) begin
                        vtx_we = 1'b1;
                        vtx_vld_in[vtx_waddr] = 1'b1;
                     end
                  end
                  OP_TRI: begin
                     if (corners_ok) begin
                        corner_in[0] = req_data.corner_a[IDX_W-1:0];
                        corner_in[1] = req_data.corner_b[IDX_W-1:0];
                        corner_in[2] = req_data.corner_c[IDX_W-1:0];
                        op_in    = OP_TRI;
                        state_in = S_RDA;
                     end
                  end
                  OP_EMIT: begin
                     if (emit_cnt == 7'd0) begin
                        acc_vld_in = '0;
                        flag_in    = 1'b0;
                     end else begin
                        op_in    = OP_EMIT;
                        idx_in   = '0;
                        state_in = S_ERD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RDA: begin
            vtx_raddr = corner_ff[0];
            state_in  = S_RDB;
         end
         S_RDB: begin
            vtx_raddr = corner_ff[1];
            for (int i = 0; i < 3; i++) v0_in[i] = vtx_f[i];
            state_in = S_RDC;
         end
         S_RDC: begin
            vtx_raddr = corner_ff[2];
            for (int i = 0; i < 3; i++) v1_in[i] = vtx_f[i];
            state_in = S_RDW;
         end
         S_RDW: begin
            for (int i = 0; i < 3; i++) v2_in[i] = vtx_f[i];
            state_in = S_DIFF;
         end
         S_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = DW'(v0_ff[i]) - DW'(v1_ff[i]);
               e2_in[i] = DW'(v0_ff[i]) - DW'(v2_ff[i]);
            end
            cnt_in   = '0;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            // even step: multiply; odd step: fold the registered product in
            if (cnt_ff[0]) begin
               if (!cnt_ff[1]) cr_in[cnt_ff[3:2]] = XW'(prod_ff);
               else            cr_in[cnt_ff[3:2]] = cr_ff[cnt_ff[3:2]] - XW'(prod_ff);
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd11) state_in = S_SGN;
         end
         S_SGN: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = cr_ff[i][XW-1];
               mag_in[i] = cr_ff[i][XW-1] ? $unsigned(-cr_ff[i]) : $unsigned(cr_ff[i]);
            end
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            if (mag_or == '0) begin
               for (int i = 0; i < 3; i++) n_in[i] = '0;
               if (op_ff == OP_TRI) begin
                  flag_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EOUT;
               end
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (|mag_or[XW-1:30]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!mag_or[29]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               comp_in  = '0;
               sum_in   = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (cnt_ff[0]) begin
               sum_in  = sum_nx;
               comp_in = comp_ff + 2'd1;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) begin
               srem_in  = RW'(sum_nx);
               root_in  = '0;
               sbit_in  = RW'(1) << 62;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (srem_ff >= sq_t) begin
               srem_in = srem_ff - sq_t;
               root_in = (root_ff >> 1) + sbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (sbit_ff[0]) begin
               len_in   = root_in[30:0];
               comp_in  = '0;
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            rem_in   = NW'({mag_ff[comp_ff][29:0], 14'd0}) + NW'(len_ff >> 1);
            dvs_in   = NW'(len_ff) << 14;
            q_in     = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (qbit) rem_in = trial[NW-1:0];
            q_in   = q_nx;
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(QW - 1)) begin
               n_in[comp_ff] = neg_ff[comp_ff] ? -16'(q_nx) : 16'(q_nx);
               if (comp_ff == 2'd2) begin
                  if (op_ff == OP_TRI) begin
                     ucnt_in  = '0;
                     state_in = S_URD;
                  end else begin
                     state_in = S_EOUT;
                  end
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_DINIT;
               end
            end
         end
         S_URD: begin
            acc_raddr = cur_corner;
            state_in  = S_UWR;
         end
         S_UWR: begin
            // write lands before the next corner's read, so repeats chain
            acc_we    = 1'b1;
            acc_wdata = {sat_sub(acc_f[0], n_ff[0]), sat_sub(acc_f[1], n_ff[1]),
                         sat_sub(acc_f[2], n_ff[2])};
            acc_vld_in[cur_corner] = 1'b1;
            if (ucnt_ff == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               ucnt_in  = ucnt_ff + 2'd1;
               state_in = S_URD;
            end
         end
         S_ERD: begin
            acc_raddr = idx_ff;
            state_in  = S_ELD;
         end
         S_ELD: begin
            for (int i = 0; i < 3; i++) begin
               xv        = XW'($signed(acc_f[i]));
               neg_in[i] = xv[XW-1];
               mag_in[i] = xv[XW-1] ? $unsigned(-xv) : $unsigned(xv);
            end
            state_in = S_ZCHK;
         end
         S_EOUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.normal_index    = 6'(idx_ff);
            rsp_data_in.normal_x        = n_ff[0];
            rsp_data_in.normal_y        = n_ff[1];
            rsp_data_in.normal_z        = n_ff[2];
            rsp_data_in.degenerate_seen = flag_ff;
            rsp_data_in.last_normal     = last_v;
            if (last_v) begin
               acc_vld_in = '0;
               flag_in    = 1'b0;
               state_in   = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (vtx_we) vtx_mem[vtx_waddr] <= vtx_wdata;
      vtx_rd_ff     <= vtx_mem[vtx_raddr];
      vtx_rd_vld_ff <= vtx_vld_ff[vtx_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      acc_rd_ff     <= acc_mem[acc_raddr];
      acc_rd_vld_ff <= acc_vld_ff[acc_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flag_ff      <= 1'b0;
         viu_ff       <= VIU_RESET;
         rsp_valid_ff <= 1'b0;
         vtx_vld_ff   <= '0;
         acc_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         viu_ff       <= viu_in;
         rsp_valid_ff <= rsp_valid_in;
         vtx_vld_ff   <= vtx_vld_in;
         acc_vld_ff   <= acc_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      comp_ff     <= comp_in;
      ucnt_ff     <= ucnt_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      sbit_ff     <= sbit_in;
      len_ff      <= len_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      q_ff        <= q_in;
      for (int i = 0; i < 3; i++) begin
         corner_ff[i] <= corner_in[i];
         v0_ff[i]     <= v0_in[i];
         v1_ff[i]     <= v1_in[i];
         v2_ff[i]     <= v2_in[i];
         e1_ff[i]     <= e1_in[i];
         e2_ff[i]     <= e2_in[i];
         cr_ff[i]     <= cr_in[i];
         mag_ff[i]    <= mag_in[i];
         neg_ff[i]    <= neg_in[i];
         n_ff[i]      <= n_in[i];
      end
   end

endmodule

`default_nettype wire
